FILE: rtl/pcr_pkg.sv
// Shared types, constants and helpers for the pair collision response block.
package pcr_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int POS_W  = 32;
   localparam int SIZE_W = 31;
   localparam int VEC_W  = 35;
   localparam int BASE_W = 37;
   localparam int LEN_W  = 35;
   localparam int RAD_W  = 2 * LEN_W;
   localparam int SQ_W   = 2 * (VEC_W - 1);
   localparam int REM_W  = LEN_W + 2;
   localparam int DIV_W  = 32;
   localparam int DEN_W  = DIV_W + 1;

   localparam int FLAG_DYNAMIC  = 0;
   localparam int FLAG_BLOCKING = 1;
   localparam int FLAG_MOVING   = 2;
   localparam int FLAG_TRIGGER  = 3;

   typedef enum logic [1:0] {
      OP_BOX_BOX       = 2'd0,
      OP_CIRCLE_CIRCLE = 2'd1,
      OP_CIRCLE_BOX    = 2'd2,
      OP_BOX_CIRCLE    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic signed [VEC_W-1:0]   vec_x;
      logic signed [VEC_W-1:0]   vec_y;
      logic signed [BASE_W-1:0]  base;
      logic [1:0]                factor;
      logic                      trigger;
   } job_type;

   function automatic logic signed [BASE_W-1:0] clamp_val(
      input logic signed [BASE_W-1:0] v,
      input logic signed [BASE_W-1:0] lo,
      input logic signed [BASE_W-1:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

endpackage

FILE: rtl/pcr_front.sv
// Front stage: classify the pair, build the separation vector and push factor.
module pcr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_operation,
   input  logic signed [31:0]           req_a_pos_x,
   input  logic signed [31:0]           req_a_pos_y,
   input  logic [30:0]                  req_a_width_or_radius,
   input  logic [30:0]                  req_a_height,
   input  logic signed [31:0]           req_b_pos_x,
   input  logic signed [31:0]           req_b_pos_y,
   input  logic [30:0]                  req_b_width_or_radius,
   input  logic [30:0]                  req_b_height,
   input  logic [3:0]                   req_a_flags,
   input  logic [2:0]                   req_b_flags,
   output logic                         job_valid,
   input  logic                         job_ready,
   output pcr_pkg::job_type             job
);
   import pcr_pkg::*;

   logic signed [BASE_W-1:0] ax, ay, bx, by, aw, ah, bw, bh;
   logic signed [BASE_W-1:0] t_ov, b_ov, l_ov, r_ov, min_y, min_x, box_ov;
   logic signed [BASE_W-1:0] vx_in, vy_in, base_in;
   logic [1:0]               factor_in;
   logic                     am, bm;
   logic                     job_valid_ff;
   job_type                  job_ff, job_in;

   assign ax = BASE_W'(req_a_pos_x);
   assign ay = BASE_W'(req_a_pos_y);
   assign bx = BASE_W'(req_b_pos_x);
   assign by = BASE_W'(req_b_pos_y);
   assign aw = signed'(BASE_W'(req_a_width_or_radius));
   assign ah = signed'(BASE_W'(req_a_height));
   assign bw = signed'(BASE_W'(req_b_width_or_radius));
   assign bh = signed'(BASE_W'(req_b_height));

   assign t_ov   = ((ay - by) <<< 1) + ah + bh;
   assign b_ov   = ((by - ay) <<< 1) + ah + bh;
   assign l_ov   = ((bx - ax) <<< 1) + aw + bw;
   assign r_ov   = ((ax - bx) <<< 1) + aw + bw;
   assign min_y  = (t_ov < b_ov) ? t_ov : b_ov;
   assign min_x  = (l_ov < r_ov) ? l_ov : r_ov;
   assign box_ov = (min_x < min_y) ? min_x : min_y;

   always_comb begin
      vx_in   = '0;
      vy_in   = '0;
      base_in = '0;
      case (op_type'(req_operation))
         OP_BOX_BOX: begin
            base_in = box_ov;
            if (r_ov == box_ov) begin
               vx_in = BASE_W'(1);
            end else if (l_ov == box_ov) begin
               vx_in = -BASE_W'(1);
            end else if (b_ov == box_ov) begin
               vy_in = -BASE_W'(1);
            end else begin
               vy_in = BASE_W'(1);
            end
         end
         OP_CIRCLE_CIRCLE: begin
            vx_in   = bx - ax;
            vy_in   = by - ay;
            base_in = aw + bw;
         end
         OP_CIRCLE_BOX: begin
            vx_in   = clamp_val(ax <<< 1, (bx <<< 1) - bw, (bx <<< 1) + bw) - (ax <<< 1);
            vy_in   = clamp_val(ay <<< 1, (by <<< 1) - bh, (by <<< 1) + bh) - (ay <<< 1);
            base_in = aw <<< 1;
         end
         default: begin
            vx_in   = (bx <<< 1) - clamp_val(bx <<< 1, (ax <<< 1) - aw, (ax <<< 1) + aw);
            vy_in   = (by <<< 1) - clamp_val(by <<< 1, (ay <<< 1) - ah, (ay <<< 1) + ah);
            base_in = bw <<< 1;
         end
      endcase
   end

   assign am = req_a_flags[FLAG_MOVING];
   assign bm = req_b_flags[FLAG_MOVING];

   always_comb begin
      factor_in = 2'd0;
      if (req_a_flags[FLAG_DYNAMIC] && req_a_flags[FLAG_BLOCKING] &&
          req_b_flags[FLAG_BLOCKING]) begin
         if ((am == bm) || !req_b_flags[FLAG_DYNAMIC]) begin
            factor_in = 2'd1;
         end else if (!am && bm) begin
            factor_in = 2'd2;
         end
      end
   end

   always_comb begin
      job_in.op      = op_type'(req_operation);
      job_in.vec_x   = VEC_W'(vx_in);
      job_in.vec_y   = VEC_W'(vy_in);
      job_in.base    = base_in;
      job_in.factor  = factor_in;
      job_in.trigger = req_a_flags[FLAG_TRIGGER];
   end

   assign req_ready = !job_valid_ff || job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (req_ready) begin
         job_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

FILE: rtl/pcr_queue.sv
// Two-entry queue between the front and back parts.
module pcr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  pcr_pkg::job_type  wr_job,
   output logic              rd_valid,
   input  logic              rd_ready,
   output pcr_pkg::job_type  rd_job
);
   import pcr_pkg::*;

   job_type     mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

FILE: rtl/pcr_back.sv
// Back pipeline: squares, bit-serial root, push products, pipelined divide, output.
module pcr_back #(
   parameter int COORD_WIDTH = pcr_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  pcr_pkg::job_type  job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_touching,
   output logic              rsp_record_contact,
   output logic signed [31:0] rsp_push_x,
   output logic signed [31:0] rsp_push_y,
   output logic signed [31:0] rsp_overlap_depth,
   output logic              rsp_degenerate
);
   import pcr_pkg::*;

   localparam int SQRT_N = LEN_W;
   localparam int DIV_N  = DIV_W;
   localparam int PUSH_W = 40;
   localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

   typedef struct packed {
      job_type                   job;
      logic signed [BASE_W-1:0]  ov;
      logic                      touch;
      logic                      degen;
   } info_type;

   function automatic logic [31:0] sat_out(input logic signed [PUSH_W-1:0] v);
      logic signed [65:0] w;
      w = 66'(v);
      if (w > SAT_HI) return SAT_HI[31:0];
      if (w < SAT_LO) return SAT_LO[31:0];
      return w[31:0];
   endfunction

   function automatic logic [VEC_W-2:0] mag(input logic signed [VEC_W-1:0] v);
      return (VEC_W-1)'(v < 0 ? -v : v);
   endfunction

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign job_ready = adv;

   // squares
   logic            sa_vld_ff;
   job_type         sa_job_ff;
   logic [SQ_W-1:0] sa_sqx_ff, sa_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else if (adv) begin
         sa_vld_ff <= job_valid;
      end
      if (adv) begin
         sa_job_ff <= job;
         sa_sqx_ff <= mag(job.vec_x) * mag(job.vec_x);
         sa_sqy_ff <= mag(job.vec_y) * mag(job.vec_y);
      end
   end

   // square root, one result bit per stage
   logic [SQRT_N:0]    sq_vld_ff;
   job_type            sq_job_ff  [SQRT_N+1];
   logic [RAD_W-1:0]   sq_rad_ff  [SQRT_N+1];
   logic [REM_W-1:0]   sq_rem_ff  [SQRT_N+1];
   logic [LEN_W-1:0]   sq_root_ff [SQRT_N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= sa_vld_ff;
      end
      if (adv) begin
         sq_job_ff[0]  <= sa_job_ff;
         sq_rad_ff[0]  <= RAD_W'(sa_sqx_ff) + RAD_W'(sa_sqy_ff);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
      logic [REM_W+1:0] rem_in;
      logic [REM_W+1:0] trial_in;
      assign rem_in   = {sq_rem_ff[i], sq_rad_ff[i][RAD_W-1 -: 2]};
      assign trial_in = (REM_W+2)'({sq_root_ff[i], 2'b01});
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
         if (adv) begin
            sq_job_ff[i+1] <= sq_job_ff[i];
            sq_rad_ff[i+1] <= sq_rad_ff[i] << 2;
            if (rem_in >= trial_in) begin
               sq_rem_ff[i+1]  <= REM_W'(rem_in - trial_in);
               sq_root_ff[i+1] <= {sq_root_ff[i][LEN_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[i+1]  <= REM_W'(rem_in);
               sq_root_ff[i+1] <= {sq_root_ff[i][LEN_W-2:0], 1'b0};
            end
         end
      end
   end

   // overlap and push products; divide stage 0
   logic [LEN_W-1:0]         len;
   job_type                  m_job;
   logic signed [BASE_W-1:0] ov_in;
   info_type                 info_in;

   assign len   = sq_root_ff[SQRT_N];
   assign m_job = sq_job_ff[SQRT_N];
   assign ov_in = (m_job.op == OP_BOX_BOX) ? m_job.base
                                           : m_job.base - signed'(BASE_W'(len));

   always_comb begin
      info_in.job   = m_job;
      info_in.ov    = ov_in;
      info_in.touch = (ov_in >= 0);
      info_in.degen = (m_job.op != OP_BOX_BOX) && (len == '0);
   end

   logic [DIV_N:0]       dv_vld_ff;
   info_type             dv_info_ff [DIV_N+1];
   logic [DEN_W-1:0]     dv_den_ff  [DIV_N+1];
   logic [DEN_W-1:0]     dv_rx_ff   [DIV_N+1];
   logic [DEN_W-1:0]     dv_ry_ff   [DIV_N+1];
   logic [DIV_W-1:0]     dv_nx_ff   [DIV_N+1];
   logic [DIV_W-1:0]     dv_ny_ff   [DIV_N+1];
   logic [DIV_W-1:0]     dv_qx_ff   [DIV_N+1];
   logic [DIV_W-1:0]     dv_qy_ff   [DIV_N+1];
   logic [VEC_W-2:0]     mag_x, mag_y;
   logic [2*DIV_W-1:0]   prod_x, prod_y;

   assign mag_x  = mag(m_job.vec_x);
   assign mag_y  = mag(m_job.vec_y);
   assign prod_x = mag_x[DIV_W-1:0] * ov_in[DIV_W-1:0];
   assign prod_y = mag_y[DIV_W-1:0] * ov_in[DIV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[SQRT_N];
      end
      if (adv) begin
         dv_info_ff[0] <= info_in;
         dv_den_ff[0]  <= len[DEN_W-1:0];
         dv_rx_ff[0]   <= DEN_W'(prod_x[2*DIV_W-1:DIV_W]);
         dv_ry_ff[0]   <= DEN_W'(prod_y[2*DIV_W-1:DIV_W]);
         dv_nx_ff[0]   <= prod_x[DIV_W-1:0];
         dv_ny_ff[0]   <= prod_y[DIV_W-1:0];
         dv_qx_ff[0]   <= '0;
         dv_qy_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [DEN_W:0] rx_in, ry_in, den_in;
      assign rx_in  = {dv_rx_ff[j], dv_nx_ff[j][DIV_W-1]};
      assign ry_in  = {dv_ry_ff[j], dv_ny_ff[j][DIV_W-1]};
      assign den_in = (DEN_W+1)'(dv_den_ff[j]);
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         if (adv) begin
            dv_info_ff[j+1] <= dv_info_ff[j];
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_nx_ff[j+1]   <= dv_nx_ff[j] << 1;
            dv_ny_ff[j+1]   <= dv_ny_ff[j] << 1;
            if (rx_in >= den_in) begin
               dv_rx_ff[j+1] <= DEN_W'(rx_in - den_in);
               dv_qx_ff[j+1] <= {dv_qx_ff[j][DIV_W-2:0], 1'b1};
            end else begin
               dv_rx_ff[j+1] <= DEN_W'(rx_in);
               dv_qx_ff[j+1] <= {dv_qx_ff[j][DIV_W-2:0], 1'b0};
            end
            if (ry_in >= den_in) begin
               dv_ry_ff[j+1] <= DEN_W'(ry_in - den_in);
               dv_qy_ff[j+1] <= {dv_qy_ff[j][DIV_W-2:0], 1'b1};
            end else begin
               dv_ry_ff[j+1] <= DEN_W'(ry_in);
               dv_qy_ff[j+1] <= {dv_qy_ff[j][DIV_W-2:0], 1'b0};
            end
         end
      end
   end

   // scale, sign and saturate
   info_type                  f_info;
   logic                      f_box, f_half, f_push;
   logic [BASE_W-1:0]         qx_in, qy_in;
   logic [BASE_W:0]           mx_in, my_in;
   logic signed [PUSH_W-1:0]  px_in, py_in, depth_in;
   logic signed [31:0]        push_x_ff, push_y_ff, depth_ff;
   logic                      touch_ff, contact_ff, degen_ff;

   assign f_info = dv_info_ff[DIV_N];
   assign f_box  = (f_info.job.op == OP_BOX_BOX);
   assign f_half = (f_info.job.op != OP_CIRCLE_CIRCLE);
   assign f_push = f_info.touch && (f_info.job.factor != 2'd0) && !f_info.degen;

   always_comb begin
      if (f_box) begin
         qx_in = (f_info.job.vec_x != '0) ? f_info.ov : '0;
         qy_in = (f_info.job.vec_y != '0) ? f_info.ov : '0;
      end else begin
         qx_in = BASE_W'(dv_qx_ff[DIV_N]);
         qy_in = BASE_W'(dv_qy_ff[DIV_N]);
      end
      mx_in = (f_info.job.factor == 2'd2) ? {qx_in, 1'b0} : {1'b0, qx_in};
      my_in = (f_info.job.factor == 2'd2) ? {qy_in, 1'b0} : {1'b0, qy_in};
      if (f_half) begin
         mx_in = mx_in >> 1;
         my_in = my_in >> 1;
      end
      px_in = '0;
      py_in = '0;
      if (f_push) begin
         px_in = (f_info.job.vec_x > 0) ? -signed'(PUSH_W'(mx_in)) : signed'(PUSH_W'(mx_in));
         py_in = (f_info.job.vec_y > 0) ? -signed'(PUSH_W'(my_in)) : signed'(PUSH_W'(my_in));
      end
      depth_in = f_half ? PUSH_W'(f_info.ov >>> 1) : PUSH_W'(f_info.ov);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_vld_ff[DIV_N];
      end
      if (adv) begin
         touch_ff   <= f_info.touch;
         contact_ff <= f_info.touch && f_info.job.trigger;
         degen_ff   <= f_info.degen;
         push_x_ff  <= sat_out(px_in);
         push_y_ff  <= sat_out(py_in);
         depth_ff   <= sat_out(depth_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_touching       = touch_ff;
   assign rsp_record_contact = contact_ff;
   assign rsp_push_x         = push_x_ff;
   assign rsp_push_y         = push_y_ff;
   assign rsp_overlap_depth  = depth_ff;
   assign rsp_degenerate     = degen_ff;

   a_no_push_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touching |-> rsp_push_x == '0 && rsp_push_y == '0 &&
      !rsp_record_contact)
      else $error("push or contact on a separated pair");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_touching && rsp_push_x == '0 &&
      rsp_push_y == '0)
      else $error("degenerate pair with nonzero push");

   a_depth_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && COORD_WIDTH == 32 |-> rsp_touching == !rsp_overlap_depth[31])
      else $error("touching disagrees with depth sign");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_push_x) && $stable(rsp_push_y))
      else $error("result changed while stalled");

endmodule

FILE: rtl/pair_collision_response.sv
// Top level of the pair collision response block.
// Narrow-phase test of one collider pair per transfer (box-box, circle-circle,
// circle-box, box-circle) in Q16.16. One pair is accepted every cycle when the
// output is not stalled; each result passes through the 35-stage bit-serial
// square root and the 32-stage divider of the back pipeline. A two-entry queue
// separates the classifying front stage from the back pipeline, and a stalled
// output holds the whole back pipeline.
module pair_collision_response #(
   parameter int COORD_WIDTH = pcr_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic [30:0]       req_a_width_or_radius,
   input  logic [30:0]       req_a_height,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic [30:0]       req_b_width_or_radius,
   input  logic [30:0]       req_b_height,
   input  logic [3:0]        req_a_flags,
   input  logic [2:0]        req_b_flags,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_touching,
   output logic              rsp_record_contact,
   output logic signed [31:0] rsp_push_x,
   output logic signed [31:0] rsp_push_y,
   output logic signed [31:0] rsp_overlap_depth,
   output logic              rsp_degenerate
);
   import pcr_pkg::*;

   logic    fr_valid, fr_ready, bk_valid, bk_ready;
   job_type fr_job, bk_job;

   pcr_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_a_pos_x           (req_a_pos_x),
      .req_a_pos_y           (req_a_pos_y),
      .req_a_width_or_radius (req_a_width_or_radius),
      .req_a_height          (req_a_height),
      .req_b_pos_x           (req_b_pos_x),
      .req_b_pos_y           (req_b_pos_y),
      .req_b_width_or_radius (req_b_width_or_radius),
      .req_b_height          (req_b_height),
      .req_a_flags           (req_a_flags),
      .req_b_flags           (req_b_flags),
      .job_valid             (fr_valid),
      .job_ready             (fr_ready),
      .job                   (fr_job)
   );

   pcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (fr_ready),
      .wr_job   (fr_job),
      .rd_valid (bk_valid),
      .rd_ready (bk_ready),
      .rd_job   (bk_job)
   );

   pcr_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (bk_valid),
      .job_ready          (bk_ready),
      .job                (bk_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_touching       (rsp_touching),
      .rsp_record_contact (rsp_record_contact),
      .rsp_push_x         (rsp_push_x),
      .rsp_push_y         (rsp_push_y),
      .rsp_overlap_depth  (rsp_overlap_depth),
      .rsp_degenerate     (rsp_degenerate)
   );

endmodule

FILE: tb/pair_collision_response_checker.sv
// Checker for the pair collision response block: predicts each result and compares.
module pair_collision_response_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic [30:0]        req_a_width_or_radius,
   input  logic [30:0]        req_a_height,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic [30:0]        req_b_width_or_radius,
   input  logic [30:0]        req_b_height,
   input  logic [3:0]         req_a_flags,
   input  logic [2:0]         req_b_flags,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_touching,
   input  logic               rsp_record_contact,
   input  logic signed [31:0] rsp_push_x,
   input  logic signed [31:0] rsp_push_y,
   input  logic signed [31:0] rsp_overlap_depth,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcr_pkg::*;

   typedef struct packed {
      logic               touching;
      logic               record_contact;
      logic signed [31:0] push_x;
      logic signed [31:0] push_y;
      logic signed [31:0] depth;
      logic               degenerate;
   } contact_type;

   contact_type expected_contacts[$];

   function automatic logic [63:0] isqrt128(input logic [127:0] sq);
      logic [127:0] root;
      logic [127:0] rem;
      logic [127:0] trial;
      root = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((sq >> (2 * i)) & 128'd3);
         trial = (root << 2) | 128'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 128'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic [63:0] vec_len(input longint vx, input longint vy);
      logic [127:0] mx;
      logic [127:0] my;
      mx = (vx < 0) ? -vx : vx;
      my = (vy < 0) ? -vy : vy;
      return isqrt128(mx * mx + my * my);
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint push_axis(input longint v, input longint ov, input longint len,
                                        input int k, input int sh);
      logic [127:0] q;
      longint m;
      q = (((v < 0) ? -v : v) * 128'(ov)) / 128'(len);
      m = longint'((q * k) >> sh);
      return (v > 0) ? -m : m;
   endfunction

   function automatic contact_type predict_contact(
      input op_type op, input longint ax, input longint ay, input longint aw,
      input longint ah, input longint bx, input longint by, input longint bw,
      input longint bh, input logic [3:0] af, input logic [2:0] bf);
      contact_type c;
      longint vx, vy, ov, depth, len, t, b, l, r, px, py;
      int k, sh;
      logic degen, am, bm;
      vx = 0; vy = 0; len = 1; sh = 1; k = 0; px = 0; py = 0; degen = 0;
      case (op)
         OP_BOX_BOX: begin
            t = 2 * (ay - by) + ah + bh;
            b = 2 * (by - ay) + ah + bh;
            l = 2 * (bx - ax) + aw + bw;
            r = 2 * (ax - bx) + aw + bw;
            ov = r;
            if (l < ov) ov = l;
            if (t < ov) ov = t;
            if (b < ov) ov = b;
            if (r == ov) vx = 1;
            else if (l == ov) vx = -1;
            else if (b == ov) vy = -1;
            else vy = 1;
         end
         OP_CIRCLE_CIRCLE: begin
            vx = bx - ax;
            vy = by - ay;
            sh = 0;
            len = vec_len(vx, vy);
            ov = aw + bw - len;
         end
         OP_CIRCLE_BOX: begin
            vx = clip(2 * ax, 2 * bx - bw, 2 * bx + bw) - 2 * ax;
            vy = clip(2 * ay, 2 * by - bh, 2 * by + bh) - 2 * ay;
            len = vec_len(vx, vy);
            ov = 2 * aw - len;
         end
         default: begin
            vx = 2 * bx - clip(2 * bx, 2 * ax - aw, 2 * ax + aw);
            vy = 2 * by - clip(2 * by, 2 * ay - ah, 2 * ay + ah);
            len = vec_len(vx, vy);
            ov = 2 * bw - len;
         end
      endcase
      c.touching = (ov >= 0);
      depth = (sh != 0) ? (ov >>> 1) : ov;
      degen = (op != OP_BOX_BOX) && (len == 0);
      if (c.touching && af[FLAG_DYNAMIC] && af[FLAG_BLOCKING] && bf[FLAG_BLOCKING]) begin
         am = af[FLAG_MOVING];
         bm = bf[FLAG_MOVING];
         if (am == bm || !bf[FLAG_DYNAMIC]) k = 1;
         else if (bm) k = 2;
      end
      if (k != 0 && !degen) begin
         px = push_axis(vx, ov, len, k, sh);
         py = push_axis(vy, ov, len, k, sh);
      end
      c.record_contact = c.touching && af[FLAG_TRIGGER];
      c.push_x = sat32(px);
      c.push_y = sat32(py);
      c.depth = sat32(depth);
      c.degenerate = degen;
      return c;
   endfunction

   contact_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         expected_contacts.delete();
      end else begin
         if (req_valid && req_ready)
            expected_contacts.insert(expected_contacts.size(),
               predict_contact(op_type'(req_operation),
               req_a_pos_x, req_a_pos_y, req_a_width_or_radius, req_a_height,
               req_b_pos_x, req_b_pos_y, req_b_width_or_radius, req_b_height,
               req_a_flags, req_b_flags));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_touching, rsp_record_contact, rsp_push_x, rsp_push_y,
                    rsp_overlap_depth, rsp_degenerate};
            if (expected_contacts.size() == 0) begin
               if (fail_count < 10) $display("unexpected transfer on rsp channel");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_contacts.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: exp t%0d c%0d px%0d py%0d d%0d g%0d, %s",
                        want.touching, want.record_contact, want.push_x, want.push_y,
                        want.depth, want.degenerate,
                        $sformatf("got t%0d c%0d px%0d py%0d d%0d g%0d",
                        got.touching, got.record_contact,
                        got.push_x, got.push_y, got.depth, got.degenerate));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = expected_contacts.size();

endmodule

FILE: tb/pair_collision_response_tb.sv
// Testbench top for the pair collision response block: stimulus and verdict.
module pair_collision_response_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcr_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready;
   logic [1:0]         req_operation;
   logic signed [31:0] req_a_pos_x, req_a_pos_y, req_b_pos_x, req_b_pos_y;
   logic [30:0]        req_a_width_or_radius, req_a_height;
   logic [30:0]        req_b_width_or_radius, req_b_height;
   logic [3:0]         req_a_flags;
   logic [2:0]         req_b_flags;
   logic               rsp_valid, rsp_ready;
   logic               rsp_touching, rsp_record_contact, rsp_degenerate;
   logic signed [31:0] rsp_push_x, rsp_push_y, rsp_overlap_depth;
   int                 fail_count, pending_count;
   int                 idle_cycles;
   logic               sending_done;
   logic               hold_rsp;

   pair_collision_response u_top (.*);

   pair_collision_response_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 | $urandom_range(0, 3);
         2: return 32'h7fff_fffc | $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [30:0] rand_size();
      case ($urandom_range(0, 5))
         0: return 31'($urandom);
         1: return 31'h7fff_ffff;
         2: return '0;
         default: return 31'($urandom_range(0, 32'h0010_0000));
      endcase
   endfunction

   task automatic send_pair(input op_type op, input logic [31:0] ax, input logic [31:0] ay,
                            input logic [30:0] aw, input logic [30:0] ah,
                            input logic [31:0] bx, input logic [31:0] by,
                            input logic [30:0] bw, input logic [30:0] bh,
                            input logic [3:0] af, input logic [2:0] bf);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_a_pos_x <= ax; req_a_pos_y <= ay;
      req_a_width_or_radius <= aw; req_a_height <= ah;
      req_b_pos_x <= bx; req_b_pos_y <= by;
      req_b_width_or_radius <= bw; req_b_height <= bh;
      req_a_flags <= af; req_b_flags <= bf;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] ax, ay;
      ax = rand_coord();
      ay = rand_coord();
      if ($urandom_range(0, 3) != 0)
         send_pair(op_type'($urandom_range(0, 3)), ax, ay, rand_size(), rand_size(),
                   ax + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                   ay + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                   rand_size(), rand_size(), 4'($urandom), 3'($urandom));
      else
         send_pair(op_type'($urandom_range(0, 3)), ax, ay, 31'($urandom), 31'($urandom),
                   rand_coord(), rand_coord(), 31'($urandom), 31'($urandom),
                   4'($urandom), 3'($urandom));
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_operation = OP_BOX_BOX;
      {req_a_pos_x, req_a_pos_y, req_b_pos_x, req_b_pos_y} = '0;
      {req_a_width_or_radius, req_a_height, req_b_width_or_radius, req_b_height} = '0;
      req_a_flags = 0;
      req_b_flags = 0;
      sending_done = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: tie order, zero distance, extremes, each push factor
      for (int op = 0; op < 4; op++) begin
         send_pair(op_type'(op), 0, 0, 31'h10000, 31'h10000, 0, 0, 31'h10000, 31'h10000,
                   4'hb, 3'h3);
         send_pair(op_type'(op), 32'h8000, 0, 31'h20000, 31'h20000, 0, 32'h4000,
                   31'h20000, 31'h10000, 4'h3, 3'h7);
         send_pair(op_type'(op), 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                   31'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                   31'h7fff_ffff, 4'hf, 3'h7);
         send_pair(op_type'(op), 32'h7fff_ffff, 32'h8000_0000, 31'd0, 31'd0, 32'h8000_0000,
                   32'h7fff_ffff, 31'd0, 31'd0, 4'h7, 3'h2);
         send_pair(op_type'(op), 0, 0, 31'h30000, 31'h30000, 32'h1000, 32'hffff_f000,
                   31'h30000, 31'h30000, 4'h7, 3'h3);
         send_pair(op_type'(op), 32'h50000, 0, 31'h10000, 31'h10000, 0, 0, 31'h10000,
                   31'h10000, 4'h8, 3'h0);
      end
      repeat (1100) send_random();
      req_valid <= 0;
      sending_done <= 1;
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      hold_rsp = 0;
      @(negedge reset);
      repeat (40) @(posedge clock);
      hold_rsp <= 1;
      repeat (400) @(posedge clock);
      hold_rsp <= 0;
   end

   initial begin
      int g;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= !hold_rsp;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= 5000) begin
            $display("pair_collision_response test failed");
            $finish;
         end
      end
   end

   initial begin
      @(negedge reset);
      wait (sending_done && pending_count == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("pair_collision_response test passed");
      else
         $display("pair_collision_response test failed");
      $finish;
   end

endmodule
